@@ src/vrst_pkg.sv @@
// shared types and constants for the voxel ray segment traversal unit
`timescale 1ns / 1ps
`default_nettype none
package vrst_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM = 3'd4;

    localparam int DEF_MAX_STEPS    = 64;
    localparam int DEF_GRID_MAX_DIM = 1024;

    localparam logic [31:0] T_INF   = 32'hFFFF_FFFF;
    localparam logic [31:0] T_LIMIT = 32'd1073742898;
    localparam logic [47:0] G_MAX   = 48'h3FFF_FFFF_FFFF;
    localparam logic [48:0] G_NEG_MAX = 49'h4000_0000_0000;

    localparam int DIV_BITS = 32;

    localparam logic [1:0] SGN_ZERO = 2'd0;
    localparam logic [1:0] SGN_POS  = 2'd1;
    localparam logic [1:0] SGN_NEG  = 2'd2;

    typedef struct packed {
        logic       cap;
        logic       conv_sub;
        logic       conv_mul;
        logic       conv_fin;
        logic [2:0] conv_idx;
        logic       prep;
        logic       div_start;
        logic       div_iter;
        logic       div_wr;
        logic       div_sel;
        logic [1:0] axis;
        logic       walk;
    } cmd_t;

    typedef struct packed {
        logic       cfg_null;
        logic [2:0] axis_zero;
        logic       div_sat;
        logic       walk_last;
    } status_t;

endpackage
`default_nettype wire

@@ src/vrst_if.sv @@
// segment input and cell result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface vrst_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface vrst_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic [9:0] cell_z;
    logic       in_grid;
    logic       last;
    logic       reached_end;

    modport source (output valid, cell_x, cell_y, cell_z, in_grid, last, reached_end,
                    input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, in_grid, last, reached_end,
                  output ready);
endinterface
`default_nettype wire

@@ src/vrst_ctrl.sv @@
// sequencing state machine for setup, divisions and cell walk
`timescale 1ns / 1ps
`default_nettype none
module vrst_ctrl
    import vrst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CONV_A  = 3'd1;
    localparam logic [2:0] S_CONV_B  = 3'd2;
    localparam logic [2:0] S_CONV_C  = 3'd3;
    localparam logic [2:0] S_PREP    = 3'd4;
    localparam logic [2:0] S_DSEL    = 3'd5;
    localparam logic [2:0] S_DIV_RUN = 3'd6;
    localparam logic [2:0] S_WALK    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] axis_reg, axis_next;
    logic       sel_reg, sel_next;
    logic [4:0] dcnt_reg, dcnt_next;
    logic       wr_pend_reg, wr_pend_next;
    logic       ovalid_reg, ovalid_next;
    logic       load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        axis_next    = axis_reg;
        sel_next     = sel_reg;
        dcnt_next    = dcnt_reg;
        wr_pend_next = 1'b0;
        load         = 1'b0;
        cmd          = '0;
        cmd.conv_idx = k_reg;
        cmd.axis     = axis_reg;
        cmd.div_sel  = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap = 1'b1;
                    k_next  = 3'd0;
                    if (!status.cfg_null)
                    begin
                        state_next = S_CONV_A;
                    end
                end
            end
            S_CONV_A:
            begin
                cmd.conv_sub = 1'b1;
                state_next   = S_CONV_B;
            end
            S_CONV_B:
            begin
                cmd.conv_mul = 1'b1;
                state_next   = S_CONV_C;
            end
            S_CONV_C:
            begin
                cmd.conv_fin = 1'b1;
                if (k_reg == 3'd5)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_CONV_A;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                axis_next  = 2'd0;
                sel_next   = 1'b0;
                state_next = S_DSEL;
            end
            S_DSEL:
            begin
                if (status.axis_zero[axis_reg])
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    dcnt_next     = '0;
                    state_next    = S_DIV_RUN;
                end
            end
            S_DIV_RUN:
            begin
                if (status.div_sat || wr_pend_reg)
                begin
                    cmd.div_wr = 1'b1;
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_DSEL;
                    end
                    else
                    begin
                        sel_next = 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            state_next = S_WALK;
                        end
                        else
                        begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = S_DSEL;
                        end
                    end
                end
                else
                begin
                    cmd.div_iter = 1'b1;
                    dcnt_next    = dcnt_reg + 5'd1;
                    wr_pend_next = (dcnt_reg == 5'(DIV_BITS - 1));
                end
            end
            S_WALK:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.walk = 1'b1;
                    load     = 1'b1;
                    if (status.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ovalid_next = load || (ovalid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            axis_reg    <= '0;
            sel_reg     <= 1'b0;
            dcnt_reg    <= '0;
            wr_pend_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            axis_reg    <= axis_next;
            sel_reg     <= sel_next;
            dcnt_reg    <= dcnt_next;
            wr_pend_reg <= wr_pend_next;
            ovalid_reg  <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

@@ src/vrst_datapath.sv @@
// grid mapping, crossing divider, walk state and result register
`timescale 1ns / 1ps
`default_nettype none
module vrst_datapath
    import vrst_pkg::*;
#(
    parameter int MAX_STEPS    = DEF_MAX_STEPS,
    parameter int GRID_MAX_DIM = DEF_GRID_MAX_DIM
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [31:0]           start_x,
    input  wire logic [31:0]           start_y,
    input  wire logic [31:0]           start_z,
    input  wire logic [31:0]           end_x,
    input  wire logic [31:0]           end_y,
    input  wire logic [31:0]           end_z,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic [9:0]                 cell_x,
    output logic [9:0]                 cell_y,
    output logic [9:0]                 cell_z,
    output logic                       in_grid,
    output logic                       last,
    output logic                       reached_end
);

    localparam int SCW = $clog2(MAX_STEPS + 1);

    logic [31:0] smin_reg [3];
    logic [31:0] ics_reg;
    logic [10:0] gdim_reg;

    logic [31:0] pin_reg [6];
    logic [32:0] cmag_reg;
    logic        cneg_reg;
    logic [63:0] prod_reg;
    logic [47:0] g_reg [6];

    logic [31:0] cur_reg [3];
    logic [31:0] tgt_reg [3];
    logic [31:0] nc_reg [3];
    logic [31:0] sp_reg [3];
    logic [1:0]  sgn_reg [3];
    logic [47:0] dmag_reg [3];
    logic [16:0] dist_reg [3];
    logic [SCW-1:0] cnt_reg;

    logic [47:0] rem_reg;
    logic [31:0] lo_reg;
    logic [31:0] q_reg;
    logic        sat_reg;

    logic [9:0]  ocx_reg, ocy_reg, ocz_reg;
    logic        oin_reg, olast_reg, oreach_reg;

    // grid mapping
    logic [1:0]  min_idx;
    logic [32:0] diff;
    logic [63:0] prod_w;
    logic [48:0] qneg;
    logic [47:0] gpos;

    always_comb
    begin
        min_idx = (cmd.conv_idx >= 3'd3) ? 2'(cmd.conv_idx - 3'd3) : cmd.conv_idx[1:0];
        diff    = {pin_reg[cmd.conv_idx][31], pin_reg[cmd.conv_idx]}
                - {smin_reg[min_idx][31], smin_reg[min_idx]};
        prod_w  = 64'(cmag_reg) * 64'(ics_reg);
        gpos    = (prod_reg[63:16] > G_MAX) ? G_MAX : prod_reg[63:16];
        qneg    = 49'((65'(prod_reg) + 65'h0_FFFF) >> 16);
        if (qneg > G_NEG_MAX)
        begin
            qneg = G_NEG_MAX;
        end
    end

    // per-axis setup
    logic [48:0] dir   [3];
    logic [47:0] dmag  [3];
    logic [16:0] bdist [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dir[a]   = {g_reg[a+3][47], g_reg[a+3]} - {g_reg[a][47], g_reg[a]};
            dmag[a]  = dir[a][48] ? 48'(-dir[a]) : dir[a][47:0];
            bdist[a] = dir[a][48] ? {1'b0, g_reg[a][15:0]}
                                  : 17'h1_0000 - {1'b0, g_reg[a][15:0]};
        end
    end

    // crossing divider
    logic [46:0] dnum;
    logic [48:0] r2;
    logic        r2_ge;

    always_comb
    begin
        dnum  = cmd.div_sel ? (47'd1 << 46) : {dist_reg[cmd.axis], 30'd0};
        r2    = {rem_reg, lo_reg[31]};
        r2_ge = r2 >= {1'b0, dmag_reg[cmd.axis]};
    end

    // walk step
    logic [16:0] dim;
    logic        at_tgt;
    logic [1:0]  ax;
    logic [31:0] t;
    logic [32:0] tsum;
    logic        wlast;
    logic        ing;

    always_comb
    begin
        dim = (17'(gdim_reg) > 17'(GRID_MAX_DIM)) ? 17'(GRID_MAX_DIM) : 17'(gdim_reg);
        at_tgt = (cur_reg[0] == tgt_reg[0]) && (cur_reg[1] == tgt_reg[1])
              && (cur_reg[2] == tgt_reg[2]);
        ax = 2'd0;
        if (nc_reg[1] < nc_reg[0])
        begin
            ax = 2'd1;
        end
        if (nc_reg[2] < nc_reg[ax])
        begin
            ax = 2'd2;
        end
        t     = nc_reg[ax];
        tsum  = 33'(t) + 33'(sp_reg[ax]);
        wlast = at_tgt || (t == T_INF) || (t > T_LIMIT) || (cnt_reg == SCW'(MAX_STEPS - 1));
        ing   = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (cur_reg[a][31] || (cur_reg[a] >= 32'(dim)))
            begin
                ing = 1'b0;
            end
        end
    end

    always_comb
    begin
        status.cfg_null  = (ics_reg == 32'd0) || (gdim_reg == 11'd0);
        status.div_sat   = sat_reg;
        status.walk_last = wlast;
        for (int a = 0; a < 3; a++)
        begin
            status.axis_zero[a] = (sgn_reg[a] == SGN_ZERO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                smin_reg[a] <= '0;
                cur_reg[a]  <= '0;
                tgt_reg[a]  <= '0;
                nc_reg[a]   <= '0;
                sp_reg[a]   <= '0;
                sgn_reg[a]  <= SGN_ZERO;
            end
            ics_reg  <= 32'd65536;
            gdim_reg <= 11'd1024;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MIN_X:    smin_reg[0] <= cfg_data;
                    REG_MIN_Y:    smin_reg[1] <= cfg_data;
                    REG_MIN_Z:    smin_reg[2] <= cfg_data;
                    REG_INV_SIZE: ics_reg     <= cfg_data;
                    REG_GRID_DIM: gdim_reg    <= cfg_data[10:0];
                    default:      ;
                endcase
            end
            if (cmd.cap)
            begin
                cnt_reg <= '0;
            end
            if (cmd.prep)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cur_reg[a] <= g_reg[a][47:16];
                    tgt_reg[a] <= g_reg[a+3][47:16];
                    if (dir[a] == 49'd0)
                    begin
                        sgn_reg[a] <= SGN_ZERO;
                        nc_reg[a]  <= T_INF;
                        sp_reg[a]  <= T_INF;
                    end
                    else
                    begin
                        sgn_reg[a] <= dir[a][48] ? SGN_NEG : SGN_POS;
                    end
                end
            end
            if (cmd.div_wr)
            begin
                if (cmd.div_sel)
                begin
                    sp_reg[cmd.axis] <= sat_reg ? T_INF : q_reg;
                end
                else
                begin
                    nc_reg[cmd.axis] <= sat_reg ? T_INF : q_reg;
                end
            end
            if (cmd.walk && !wlast)
            begin
                cur_reg[ax] <= (sgn_reg[ax] == SGN_NEG) ? cur_reg[ax] - 32'd1
                                                        : cur_reg[ax] + 32'd1;
                nc_reg[ax]  <= ((sp_reg[ax] == T_INF) || (tsum >= 33'(T_INF)))
                               ? T_INF : tsum[31:0];
                cnt_reg     <= cnt_reg + SCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            pin_reg[0] <= start_x;
            pin_reg[1] <= start_y;
            pin_reg[2] <= start_z;
            pin_reg[3] <= end_x;
            pin_reg[4] <= end_y;
            pin_reg[5] <= end_z;
        end
        if (cmd.conv_sub)
        begin
            cneg_reg <= diff[32];
            cmag_reg <= diff[32] ? 33'(-diff) : diff;
        end
        if (cmd.conv_mul)
        begin
            prod_reg <= prod_w;
        end
        if (cmd.conv_fin)
        begin
            g_reg[cmd.conv_idx] <= cneg_reg ? 48'(-qneg) : gpos;
        end
        if (cmd.prep)
        begin
            for (int a = 0; a < 3; a++)
            begin
                dmag_reg[a] <= dmag[a];
                dist_reg[a] <= bdist[a];
            end
        end
        if (cmd.div_start)
        begin
            rem_reg <= {33'd0, dnum[46:32]};
            lo_reg  <= dnum[31:0];
            q_reg   <= '0;
            sat_reg <= {33'd0, dnum[46:32]} >= dmag_reg[cmd.axis];
        end
        if (cmd.div_iter)
        begin
            rem_reg <= r2_ge ? 48'(r2 - {1'b0, dmag_reg[cmd.axis]}) : r2[47:0];
            q_reg   <= {q_reg[30:0], r2_ge};
            lo_reg  <= {lo_reg[30:0], 1'b0};
        end
        if (cmd.walk)
        begin
            ocx_reg    <= ing ? cur_reg[0][9:0] : 10'd0;
            ocy_reg    <= ing ? cur_reg[1][9:0] : 10'd0;
            ocz_reg    <= ing ? cur_reg[2][9:0] : 10'd0;
            oin_reg    <= ing;
            olast_reg  <= wlast;
            oreach_reg <= at_tgt;
        end
    end

    assign cell_x      = ocx_reg;
    assign cell_y      = ocy_reg;
    assign cell_z      = ocz_reg;
    assign in_grid     = oin_reg;
    assign last        = olast_reg;
    assign reached_end = oreach_reg;

endmodule
`default_nettype wire

@@ src/voxel_ray_segment_traversal_unit.sv @@
// top level of the voxel ray segment traversal unit
//
// channel   dir   transfer unit
// in_ch     in    one segment: start and end points, world Q16.16
// out_ch    out   one visited cell: index, in_grid, last, reached_end
// cfg       in    register write: cfg_wr_en, cfg_index, cfg_data
//
// setup maps the six points to the grid through one shared multiplier, then prepares the axes
// then per moving axis two divisions, each ending early when saturated; a still axis is skipped
// then one visited cell per cycle while the output register is free, up to MAX_STEPS cells
// one segment in work at a time; the next is taken while the last cell waits in the output register
// rst_n clears control state, config and walk registers to their defaults; a full output stalls the walk
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_segment_traversal_unit
    import vrst_pkg::*;
#(
    parameter int MAX_STEPS    = DEF_MAX_STEPS,
    parameter int GRID_MAX_DIM = DEF_GRID_MAX_DIM
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    vrst_in_if.sink                    in_ch,
    vrst_out_if.source                 out_ch
);

    cmd_t    cmd;
    status_t status;

    vrst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vrst_datapath #(
        .MAX_STEPS    (MAX_STEPS),
        .GRID_MAX_DIM (GRID_MAX_DIM)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_x     (in_ch.start_x),
        .start_y     (in_ch.start_y),
        .start_z     (in_ch.start_z),
        .end_x       (in_ch.end_x),
        .end_y       (in_ch.end_y),
        .end_z       (in_ch.end_z),
        .cmd         (cmd),
        .status      (status),
        .cell_x      (out_ch.cell_x),
        .cell_y      (out_ch.cell_y),
        .cell_z      (out_ch.cell_z),
        .in_grid     (out_ch.in_grid),
        .last        (out_ch.last),
        .reached_end (out_ch.reached_end)
    );

endmodule
`default_nettype wire

@@ dv/vrst_checker.sv @@
// checker: follows register writes, predicts visited cells per segment, compares results
`timescale 1ns / 1ps
`default_nettype none
module vrst_checker
    import vrst_pkg::*;
#(
    parameter int MAX_STEPS    = DEF_MAX_STEPS,
    parameter int GRID_MAX_DIM = DEF_GRID_MAX_DIM
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    vrst_in_if                         in_ch,
    vrst_out_if                        out_ch,
    output int                         fail_count,
    output int                         cells_pending
);

    localparam longint GRID_SAT = 64'sh3FFF_FFFF_FFFF;

    typedef struct {
        logic [9:0] cell_x;
        logic [9:0] cell_y;
        logic [9:0] cell_z;
        logic       in_grid;
        logic       last;
        logic       reached_end;
    } cell_t;

    cell_t       cell_q[$];
    longint      origin[3];
    logic [31:0] inv_size;
    logic [10:0] grid_cells;

    longint      cur[3];
    longint      tgt[3];
    logic [31:0] next_cross[3];
    logic [31:0] spacing[3];
    int          dir_sign[3];

    function automatic longint world_to_grid(longint p, longint mn);
        longint    d;
        bit [63:0] mag;
        bit [63:0] prod;
        bit [63:0] q;
        d    = p - mn;
        mag  = (d < 0) ? -d : d;
        prod = mag * {32'd0, inv_size};
        if (d >= 0)
        begin
            q = prod >> 16;
            return (q > GRID_SAT) ? GRID_SAT : longint'(q);
        end
        q = (prod + 64'hFFFF) >> 16;
        if (q > GRID_SAT + 1)
            q = GRID_SAT + 1;
        return -longint'(q);
    endfunction

    function automatic logic [31:0] crossing_div(bit [63:0] num, bit [63:0] den);
        bit [63:0] q;
        q = num / den;
        return (q >= 64'hFFFF_FFFF) ? T_INF : q[31:0];
    endfunction

    function automatic void push_cell(int dim, bit last, bit reached);
        cell_t c;
        bit    in_bounds;
        in_bounds = 1;
        for (int a = 0; a < 3; a++)
            if (cur[a] < 0 || cur[a] >= dim)
                in_bounds = 0;
        c.cell_x      = in_bounds ? cur[0][9:0] : 10'd0;
        c.cell_y      = in_bounds ? cur[1][9:0] : 10'd0;
        c.cell_z      = in_bounds ? cur[2][9:0] : 10'd0;
        c.in_grid     = in_bounds;
        c.last        = last;
        c.reached_end = last & reached;
        cell_q = {cell_q, c};
    endfunction

    function automatic void predict_walk(logic signed [31:0] pt[6]);
        int          dim;
        int          ax;
        int          n;
        longint      gs;
        longint      ge;
        longint      dir;
        longint      base;
        bit [63:0]   mag;
        bit [63:0]   bnd_dist;
        bit [63:0]   sum;
        logic [31:0] t;
        dim = (grid_cells > GRID_MAX_DIM) ? GRID_MAX_DIM : int'(grid_cells);
        if (inv_size == 0 || dim == 0)
            return;
        for (int a = 0; a < 3; a++)
        begin
            gs  = world_to_grid(longint'(pt[a]), origin[a]);
            ge  = world_to_grid(longint'(pt[a+3]), origin[a]);
            dir = ge - gs;
            mag = (dir < 0) ? -dir : dir;
            cur[a] = gs >>> 16;
            tgt[a] = ge >>> 16;
            if (dir == 0)
            begin
                dir_sign[a]   = 0;
                next_cross[a] = T_INF;
                spacing[a]    = T_INF;
            end
            else
            begin
                base = cur[a] * 65536;
                if (dir > 0)
                begin
                    dir_sign[a] = 1;
                    bnd_dist = base + 65536 - gs;
                end
                else
                begin
                    dir_sign[a] = -1;
                    bnd_dist = gs - base;
                end
                next_cross[a] = crossing_div(bnd_dist << 30, mag);
                spacing[a]    = crossing_div(64'd1 << 46, mag);
            end
        end
        n = 0;
        forever
        begin
            n++;
            if (cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2])
            begin
                push_cell(dim, 1, 1);
                break;
            end
            ax = 0;
            if (next_cross[1] < next_cross[0])
                ax = 1;
            if (next_cross[2] < next_cross[ax])
                ax = 2;
            t = next_cross[ax];
            if (t == T_INF || t > T_LIMIT || n >= MAX_STEPS)
            begin
                push_cell(dim, 1, 0);
                break;
            end
            push_cell(dim, 0, 0);
            cur[ax] += dir_sign[ax];
            sum = {32'd0, t} + {32'd0, spacing[ax]};
            next_cross[ax] = (spacing[ax] == T_INF || sum >= 64'hFFFF_FFFF) ? T_INF : sum[31:0];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] pt[6];
        cell_t              e;
        if (!rst_n)
        begin
            origin     = '{0, 0, 0};
            inv_size   = 32'd65536;
            grid_cells = 11'd1024;
            fail_count = 0;
            cell_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                case (cfg_index)
                    REG_MIN_X:    origin[0] = longint'(signed'(cfg_data));
                    REG_MIN_Y:    origin[1] = longint'(signed'(cfg_data));
                    REG_MIN_Z:    origin[2] = longint'(signed'(cfg_data));
                    REG_INV_SIZE: inv_size = cfg_data;
                    REG_GRID_DIM: grid_cells = cfg_data[10:0];
                    default: ;
                endcase
            if (in_ch.valid && in_ch.ready)
            begin
                pt = '{in_ch.start_x, in_ch.start_y, in_ch.start_z,
                       in_ch.end_x, in_ch.end_y, in_ch.end_z};
                predict_walk(pt);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (cell_q.size() == 0)
                begin
                    $display("%0t: unexpected cell transfer x=%0d y=%0d z=%0d", $time,
                             out_ch.cell_x, out_ch.cell_y, out_ch.cell_z);
                    fail_count++;
                end
                else
                begin
                    e = cell_q.pop_front();
                    if (out_ch.cell_x !== e.cell_x || out_ch.cell_y !== e.cell_y ||
                        out_ch.cell_z !== e.cell_z || out_ch.in_grid !== e.in_grid ||
                        out_ch.last !== e.last || out_ch.reached_end !== e.reached_end)
                    begin
                        $display("%0t: cell mismatch expected %0d %0d %0d g%0b l%0b r%0b",
                                 $time, e.cell_x, e.cell_y, e.cell_z, e.in_grid, e.last,
                                 e.reached_end);
                        $display("%0t:               actual   %0d %0d %0d g%0b l%0b r%0b",
                                 $time, out_ch.cell_x, out_ch.cell_y, out_ch.cell_z,
                                 out_ch.in_grid, out_ch.last, out_ch.reached_end);
                        fail_count++;
                    end
                end
            end
        end
        cells_pending = cell_q.size();
    end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// testbench top: clock, reset, register phases, segment stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import vrst_pkg::*;

    typedef struct {
        logic signed [31:0] p[6];
    } segment_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    cells_pending;
    bit                    hold_req;
    int                    burst_left;
    int                    rx_mode;

    vrst_in_if  in_ch();
    vrst_out_if out_ch();

    voxel_ray_segment_traversal_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    vrst_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .cells_pending (cells_pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        int cyc;
        bit held;
        out_ch.ready <= 0;
        rx_mode = 0;
        cyc = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 173 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_req && !held)
            begin
                held = 1;
                out_ch.ready <= 0;
                repeat (400) @(posedge clk);
            end
            else
                case (rx_mode)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= (cyc % 5) != 0;
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
        end
    end

    task automatic set_config(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                              logic [31:0] inv, logic [31:0] dim);
        logic [31:0] vals[5];
        logic [CFG_IDX_W-1:0] idx[5];
        vals = '{mx, my, mz, inv, dim};
        idx  = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_INV_SIZE, REG_GRID_DIM};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 0;
        guard = 0;
        @(posedge clk);
        while (cells_pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic send_segment(segment_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1;
        in_ch.start_x <= s.p[0];
        in_ch.start_y <= s.p[1];
        in_ch.start_z <= s.p[2];
        in_ch.end_x   <= s.p[3];
        in_ch.end_y   <= s.p[4];
        in_ch.end_z   <= s.p[5];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    function automatic segment_t make_segment(logic [31:0] base, int unsigned spread,
                                              int unsigned delta);
        segment_t    s;
        logic [31:0] st;
        int          r;
        if ($urandom_range(0, 99) < 15)
        begin
            for (int i = 0; i < 6; i++)
                s.p[i] = $urandom;
            return s;
        end
        for (int a = 0; a < 3; a++)
        begin
            st = base + $urandom_range(0, spread);
            r  = $urandom_range(0, 9);
            if (r == 1)
                st[15:0] = 16'd0;
            s.p[a]   = st;
            s.p[a+3] = (r == 0) ? st : st + $urandom_range(0, 2 * delta) - delta;
        end
        return s;
    endfunction

    task automatic run_random(int count, logic [31:0] base, int unsigned spread,
                              int unsigned delta);
        for (int i = 0; i < count; i++)
            send_segment(make_segment(base, spread, delta));
    endtask

    task automatic send_points(int sx, int sy, int sz, int ex, int ey, int ez);
        segment_t s;
        s.p = '{sx, sy, sz, ex, ey, ez};
        send_segment(s);
    endtask

    localparam int U = 65536;

    initial
    begin
        rst_n        <= 0;
        cfg_wr_en    <= 0;
        cfg_index    <= REG_MIN_X;
        cfg_data     <= 0;
        in_ch.valid  <= 0;
        in_ch.start_x <= 0;
        in_ch.start_y <= 0;
        in_ch.start_z <= 0;
        in_ch.end_x   <= 0;
        in_ch.end_y   <= 0;
        in_ch.end_z   <= 0;
        hold_req   = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (3) @(posedge clk);

        // reset settings, directed segments
        send_points(U/2, U/2, U/2, U/2, U/2, U/2);
        send_points(U/2, U/2, U/2, 5*U + 3, U/2, U/2);
        send_points(U/2, 7*U, U/2, U/2, 2*U, U/2);
        send_points(9*U, 9*U, U/2, 9*U, 9*U, 6*U);
        send_points(U/2, U/2, U/2, 5*U/2, 5*U/2, 5*U/2);
        send_points(3*U, 3*U, 3*U, 0, 0, 0);
        send_points(-2*U, -U, 3*U, 4*U, 2*U, 3*U);
        send_points(U, 2*U, 3*U, 4*U, 2*U + 100, 3*U - 77);
        send_points(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_points(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000, 1, 32'sh7FFF_FFFF);
        send_points(1020*U, 1020*U, 1020*U, 1030*U, 1023*U + 5, 1021*U);
        send_points(U + 1, U - 1, U, U + 1, U - 1, U + 70000);
        send_points(0, 0, 0, 100*U, 3*U, 2*U);
        send_points(-1, -1, -1, 1, 1, 1);
        drain();

        run_random(30, 0, 40*U, 6*U);
        hold_req = 1;
        run_random(40, 0, 40*U, 6*U);
        drain();
        run_random(30, 0, 1000*U, 8*U);
        drain();

        set_config(-3*U, -3*U, -3*U, 32'h0002_0000, 16);
        run_random(80, -4*U, 12*U, 4*U);
        drain();

        set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2047);
        run_random(30, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        drain();

        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        run_random(40, 32'h7FFF_FFE0, 40, 8);
        drain();

        set_config(0, 0, 0, 0, 1024);
        run_random(5, 0, 20*U, 4*U);
        drain();

        set_config(0, 0, 0, 32'h0001_0000, 0);
        run_random(5, 0, 20*U, 4*U);
        drain();

        set_config(5*U + 123, -7*U, 0, 32'h0000_8000, 2047);
        run_random(70, 0, 60*U, 10*U);
        drain();

        if (fail_count == 0 && cells_pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
src/vrst_pkg.sv
src/vrst_if.sv
src/vrst_ctrl.sv
src/vrst_datapath.sv
src/voxel_ray_segment_traversal_unit.sv
dv/vrst_checker.sv
dv/testbench.sv
